// File: src/lzr_pkg.sv
// Shared types and constants for the LZSS ring decompressor.
`timescale 1ns / 1ps
`default_nettype none
package lzr_pkg;

    localparam int RING_AW    = 10;
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam logic [RING_AW-1:0] RING_START = 10'd958;

    localparam int CNT_W  = 24;   // decoded length and produced count
    localparam int LEN_W  = 7;    // match length, 3..66
    localparam logic [LEN_W-1:0] LEN_BIAS = 7'd3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic [1:0] BC_ONE = 2'd1;
    localparam logic [1:0] BC_TWO = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MRD,
        S_MWR
    } t_state;

    typedef struct packed {
        logic latch;       // capture the accepted input transaction
        logic start;       // reset stream registers, rewind clear sweep
        logic clear_wr;    // write one zero during the clear sweep
        logic load_flag;   // load a new flag byte
        logic literal;     // emit and store a literal byte
        logic store_low;   // hold the low offset byte of a match
        logic match_start; // set up the copy of a match
        logic mrd;         // read one history byte
        logic mwr;         // store the history byte just read; emit it or hold it for a pair
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic done;
        logic phase;
        logic flag_needed;
        logic flag_lit;
        logic last_byte;
        logic need_slot;
        logic slot_free;
        logic clr_last;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: src/lzss_ring_decompressor.sv
// Top level of the LZSS ring decompressor with a 1024-byte history window.
`timescale 1ns / 1ps
`default_nettype none
// Decodes an LZSS stream fed one compressed byte per input transaction.
// tuser = 0 starts a new stream: stream state is reset and the 1024-byte
// history ring is swept to zero, one entry per cycle, while no input is
// taken (the same sweep runs after reset). With tuser = 1, tdata carries
// a compressed byte: flag bytes are read LSB first, 1 = literal, 0 =
// two-byte match (10-bit absolute ring offset, length 3..66). Decoded
// bytes leave one or two per output transaction; tlast marks the
// last output of an input byte, and the done bit rises once the number of
// decoded bytes reaches the configured length, after which compressed bytes
// are dropped until the next start. Write the length only while idle.
// Steps: a flag byte, a first match byte or a literal passes IDLE and
// DECODE; a second match byte then copies each byte with a read step and
// a write step on the single ring RAM. A full output register that is
// not drained stalls emission; the next input is still taken while a
// finished result waits.
module lzss_ring_decompressor
    import lzr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [23:0]  i_cfg_wdata,    // decoded_length
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // [7:0] in_byte
    input  wire         s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] first, [15:8] second, [17:16] count,
                                        // [18] stream_done, [23:19] zero
    output logic        m_axis_tlast    // last_of_run
);

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [1:0] out_count;
    logic       out_done;

    // Sequence decode, copy and clear steps
    lzr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold stream state, history ring and the output register
    lzr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_cmd    (s_axis_tuser),
        .i_in_byte   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_first     (out_first),
        .o_second    (out_second),
        .o_count     (out_count),
        .o_last      (m_axis_tlast),
        .o_done      (out_done)
    );

    assign m_axis_tdata = {5'd0, out_done, out_count, out_second, out_first};

endmodule
`default_nettype wire

// File: src/lzr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lzr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/lzr_ctrl.sv
// Controller state machine of the LZSS ring decompressor.
`timescale 1ns / 1ps
`default_nettype none
module lzr_ctrl
    import lzr_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_s_tvalid,
    output logic           o_s_tready,
    input  wire t_dp_stat  i_stat,
    output t_dp_cmd        o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_start) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CLEAR;
                end else if (i_stat.done) begin
                    n_state = S_IDLE;
                end else if (!i_stat.phase) begin
                    if (i_stat.flag_needed) begin
                        o_cmd.load_flag = 1'b1;
                        n_state         = S_IDLE;
                    end else if (i_stat.flag_lit) begin
                        // hold until the output register can take the byte
                        if (i_stat.slot_free) begin
                            o_cmd.literal = 1'b1;
                            n_state       = S_IDLE;
                        end
                    end else begin
                        o_cmd.store_low = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.match_start = 1'b1;
                    n_state           = S_MRD;
                end
            end
            S_MRD: begin
                o_cmd.mrd = 1'b1;
                n_state   = S_MWR;
            end
            S_MWR: begin
                if (!i_stat.need_slot || i_stat.slot_free) begin
                    o_cmd.mwr = 1'b1;
                    n_state   = i_stat.last_byte ? S_IDLE : S_MRD;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/lzr_dp.sv
// Datapath of the LZSS ring decompressor: stream registers, history ring, output register.
`timescale 1ns / 1ps
`default_nettype none
module lzr_dp
    import lzr_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [CNT_W-1:0]   i_cfg_wdata,
    input  wire               i_in_cmd,
    input  wire [7:0]         i_in_byte,
    input  wire t_dp_cmd      i_cmd,
    output t_dp_stat          o_stat,
    input  wire               i_m_tready,
    output logic              o_m_tvalid,
    output logic [7:0]        o_first,
    output logic [7:0]        o_second,
    output logic [1:0]        o_count,
    output logic              o_last,
    output logic              o_done
);

    logic               r_cmd;
    logic [7:0]         r_byte;
    logic [RING_AW-1:0] r_wp;
    logic [8:0]         r_flag;
    logic               r_phase;
    logic [7:0]         r_off_low;
    logic [CNT_W-1:0]   r_prod;
    logic [CNT_W-1:0]   r_len_cfg;
    logic [RING_AW-1:0] r_src;
    logic [LEN_W-1:0]   r_cnt;
    logic [7:0]         r_held;
    logic               r_have;
    logic [RING_AW-1:0] r_clr_addr;
    logic               r_out_valid;

    logic [CNT_W-1:0]   n_prod;
    logic               done_next;
    logic [CNT_W-1:0]   remain;
    logic [LEN_W-1:0]   len_raw;
    logic [LEN_W-1:0]   len_cut;
    logic [7:0]         rdata;
    logic               ram_we;
    logic [RING_AW-1:0] ram_waddr;
    logic [7:0]         ram_wdata;

    assign n_prod    = r_prod + CNT_W'(1);
    assign done_next = (n_prod >= r_len_cfg);
    assign remain    = r_len_cfg - r_prod;
    assign len_raw   = {1'b0, r_byte[5:0]} + LEN_BIAS;
    assign len_cut   = (remain < CNT_W'(len_raw)) ? remain[LEN_W-1:0] : len_raw;

    always_comb begin
        ram_we    = i_cmd.clear_wr | i_cmd.literal | i_cmd.mwr;
        ram_waddr = r_wp;
        ram_wdata = i_cmd.literal ? r_byte : rdata;
        if (i_cmd.clear_wr) begin
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end
    end

    lzr_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.mrd),
        .i_raddr (r_src),
        .o_rdata (rdata)
    );

    assign o_stat.is_start    = (r_cmd == CMD_START);
    assign o_stat.done        = (r_prod >= r_len_cfg);
    assign o_stat.phase       = r_phase;
    assign o_stat.flag_needed = (r_flag[8:1] == 8'd0);
    assign o_stat.flag_lit    = r_flag[0];
    assign o_stat.last_byte   = (r_cnt == LEN_W'(1));
    assign o_stat.need_slot   = r_have | (r_cnt == LEN_W'(1));
    assign o_stat.slot_free   = !r_out_valid || i_m_tready;
    assign o_stat.clr_last    = (r_clr_addr == RING_AW'(RING_DEPTH - 1));

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= RING_START;
            r_flag      <= '0;
            r_phase     <= 1'b0;
            r_off_low   <= '0;
            r_prod      <= '0;
            r_len_cfg   <= '0;
            r_have      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_cmd       <= CMD_BYTE;
        end else begin
            if (i_cfg_we) begin
                r_len_cfg <= i_cfg_wdata;
            end
            if (i_cmd.latch) begin
                r_cmd <= i_in_cmd;
            end
            if (i_cmd.start) begin
                r_wp       <= RING_START;
                r_flag     <= '0;
                r_phase    <= 1'b0;
                r_off_low  <= '0;
                r_prod     <= '0;
                r_have     <= 1'b0;
                r_clr_addr <= '0;
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + RING_AW'(1);
            end
            if (i_cmd.load_flag) begin
                r_flag <= {1'b1, r_byte};
            end
            if (i_cmd.literal) begin
                r_wp   <= r_wp + RING_AW'(1);
                r_prod <= n_prod;
                r_flag <= {1'b0, r_flag[8:1]};
            end
            if (i_cmd.store_low) begin
                r_off_low <= r_byte;
                r_phase   <= 1'b1;
            end
            if (i_cmd.match_start) begin
                r_phase   <= 1'b0;
                r_off_low <= '0;
                r_flag    <= {1'b0, r_flag[8:1]};
                r_have    <= 1'b0;
            end
            if (i_cmd.mwr) begin
                r_wp   <= r_wp + RING_AW'(1);
                r_prod <= n_prod;
                r_have <= !r_have && !o_stat.last_byte;
            end
            if (i_cmd.literal || (i_cmd.mwr && o_stat.need_slot)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_byte <= i_in_byte;
        end
        if (i_cmd.match_start) begin
            r_src <= {r_byte[7:6], r_off_low};
            r_cnt <= len_cut;
        end
        if (i_cmd.mwr) begin
            r_src <= r_src + RING_AW'(1);
            r_cnt <= r_cnt - LEN_W'(1);
            if (!r_have) begin
                r_held <= rdata;
            end
        end
        if (i_cmd.literal) begin
            o_first  <= r_byte;
            o_second <= '0;
            o_count  <= BC_ONE;
            o_last   <= 1'b1;
            o_done   <= done_next;
        end else if (i_cmd.mwr && o_stat.need_slot) begin
            o_first  <= r_have ? r_held : rdata;
            o_second <= r_have ? rdata : 8'd0;
            o_count  <= r_have ? BC_TWO : BC_ONE;
            o_last   <= o_stat.last_byte;
            o_done   <= done_next;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

// File: src/lzr_checker.sv
// Port-level checks for the LZSS ring decompressor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lzr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire        m_axis_tlast
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("output transaction changed while stalled");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:16] == 2'd1 || m_axis_tdata[17:16] == 2'd2))
        else $error("byte count out of range");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17:16] == 2'd1 |-> m_axis_tlast)
        else $error("single-byte result not marked last");

    a_single_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17:16] == 2'd1 |-> m_axis_tdata[15:8] == 8'd0)
        else $error("second byte not zero on single-byte result");

endmodule

bind lzss_ring_decompressor lzr_checker u_lzr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: tb/tb_lzss_ring_decompressor.sv
// Self-checking testbench for the LZSS ring decompressor.
`timescale 1ns / 1ps

module tb_lzss_ring_decompressor;
    import lzr_pkg::*;

    // One decoded output transaction as the block should present it.
    typedef struct {
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] count;
        logic       last;
        logic       done;
    } t_decoded;

    // Scoreboard: mirrors the decoder state, turns every accepted input
    // transaction into the output transactions it should cause, and checks
    // the outputs in order.
    class lzss_scoreboard;
        logic [7:0]  ring [0:RING_DEPTH-1];
        logic [9:0]  wr_pos;
        logic [8:0]  flags;
        logic        phase;
        logic [7:0]  off_low;
        logic [23:0] produced;
        logic [23:0] length;
        t_decoded    pending_out [$];
        int          fails;

        function new();
            length = '0;
            fails  = 0;
            restart();
        endfunction

        function void restart();
            foreach (ring[i]) ring[i] = 8'h00;
            wr_pos   = RING_START;
            flags    = '0;
            phase    = 1'b0;
            off_low  = '0;
            produced = '0;
        endfunction

        function bit done();
            return produced >= length;
        endfunction

        function void store_byte(logic [7:0] v);
            ring[wr_pos] = v;
            wr_pos       = wr_pos + 10'd1;
            produced     = produced + 24'd1;
        endfunction

        function void emit(logic [7:0] a, logic [7:0] b, logic [1:0] cnt, logic last);
            t_decoded d;
            d.first  = a;
            d.second = b;
            d.count  = cnt;
            d.last   = last;
            d.done   = done();
            pending_out.push_back(d);
        endfunction

        function void note_input(logic cmd, logic [7:0] b);
            logic [9:0] offset;
            logic [9:0] idx;
            logic [7:0] v;
            logic [7:0] held;
            bit         have;
            int         len;
            int         remain;
            if (cmd == CMD_START) begin
                restart();
                return;
            end
            if (done())
                return;
            if (!phase) begin
                if (flags[8:1] == 8'h00) begin
                    flags = {1'b1, b};
                end else if (flags[0]) begin
                    store_byte(b);
                    flags = flags >> 1;
                    emit(b, 8'h00, BC_ONE, 1'b1);
                end else begin
                    off_low = b;
                    phase   = 1'b1;
                end
                return;
            end
            // Second match byte: copy from the ring, clipped at the length.
            offset = {b[7:6], off_low};
            len    = int'(b[5:0]) + 3;
            remain = int'(length - produced);
            if (len > remain)
                len = remain;
            phase   = 1'b0;
            off_low = '0;
            flags   = flags >> 1;
            have    = 1'b0;
            held    = '0;
            for (int j = 0; j < len; j++) begin
                idx = offset + j[9:0];
                v   = ring[idx];
                store_byte(v);
                if (have) begin
                    emit(held, v, BC_TWO, j + 1 == len);
                    have = 1'b0;
                end else begin
                    held = v;
                    have = 1'b1;
                end
            end
            if (have)
                emit(held, 8'h00, BC_ONE, 1'b1);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(logic [23:0] data, logic last);
            t_decoded d;
            if (pending_out.size() == 0) begin
                $error("output transaction with nothing expected: tdata %h tlast %b",
                       data, last);
                fails++;
                return;
            end
            d = pending_out.pop_front();
            compare_field("out_byte_first", d.first, data[7:0]);
            compare_field("out_byte_second", d.second, data[15:8]);
            compare_field("byte_count", {6'd0, d.count}, {6'd0, data[17:16]});
            compare_field("stream_done", {7'd0, d.done}, {7'd0, data[18]});
            compare_field("last_of_run", {7'd0, d.last}, {7'd0, last});
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [23:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    lzss_scoreboard sb;
    int          tx_calm;
    int          rx_calm;
    int          rx_wait;
    logic [1:0]  aim_hi;    // top offset bits chosen with the first match byte

    lzss_ring_decompressor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Draw the idle cycles before the next transaction on one side. Now and
    // then enter a calm stretch where that side never idles.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(10, 30);
        return $urandom_range(0, 17);
    endfunction

    // Output side: check each accepted transaction, then hold tready low for
    // a random number of cycles. Keep tready high when the draw is zero so
    // it is never lowered and raised in the same step.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
                rx_wait = draw_gap(rx_calm);
                if (rx_wait != 0)
                    m_axis_tready <= 1'b0;
            end else if (!m_axis_tready) begin
                if (rx_wait > 0)
                    rx_wait--;
                if (rx_wait == 0)
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // Present one input transaction after a random gap and wait for the
    // handshake. Lower tvalid only when a gap follows, so back-to-back
    // transactions keep it high without a second assignment in one step.
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(cmd, b);
    endtask

    // Send the byte that the decoder expects next, with random content:
    // a flag byte, a literal, or either half of a match. Match offsets
    // mostly point just behind the write position so that copies hit fresh
    // history and often overlap the bytes they write.
    task automatic send_token();
        logic [7:0] b;
        logic [9:0] offset;
        if (sb.phase) begin
            b[7:6] = aim_hi;
            b[5:0] = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 7));
        end else if (sb.flags[8:1] == 8'h00 || sb.flags[0]) begin
            b = 8'($urandom);
        end else begin
            if ($urandom_range(0, 2) != 0)
                offset = sb.wr_pos - 10'($urandom_range(1, 80));
            else
                offset = 10'($urandom_range(0, RING_DEPTH - 1));
            aim_hi = offset[9:8];
            b      = offset[7:0];
        end
        send_item(CMD_BYTE, b);
    endtask

    // Drop tvalid, drain every expected output, then let the block settle
    // (a start sweeps the whole ring with no output).
    task automatic wait_idle(input int settle);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_out.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_decoded_length(input logic [23:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.length = value;
    endtask

    initial begin
        logic [7:0]  seq [$];
        logic [23:0] len_choice;
        int          live_items;
        int          quota;

        sb            = new();
        tx_calm       = 0;
        rx_calm       = 0;
        rx_wait       = 0;
        aim_hi        = '0;
        live_items    = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= CMD_START;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full-length stream: literals 0x00 and 0xFF, a 66-byte copy that overlaps
        // its own output and wraps, a copy from offset 0, which that copy rewrote,
        // a 66-byte copy from offset 1023 that wraps, two copies, a flag byte, a copy.
        write_decoded_length(24'hFFFFFF);
        send_item(CMD_START, 8'hFF);
        seq = '{8'h0B, 8'h00, 8'hFF, 8'hBF, 8'hFF, 8'hA5, 8'h00, 8'h00,
                8'hFF, 8'hFF, 8'hBE, 8'hC1, 8'h12, 8'h45, 8'hFE, 8'h9C, 8'h21};
        foreach (seq[i]) send_item(CMD_BYTE, seq[i]);
        wait_idle(1100);

        // Overshoot: a 10-byte match with 5 bytes left ends on a single
        // byte, then the next compressed byte is dropped.
        write_decoded_length(24'd6);
        send_item(CMD_START, 8'h00);
        seq = '{8'h01, 8'h3C, 8'hBE, 8'hC7, 8'h77};
        foreach (seq[i]) send_item(CMD_BYTE, seq[i]);
        wait_idle(1100);

        // Lower the length below the count mid-stream: drop input.
        write_decoded_length(24'd3);
        send_item(CMD_BYTE, 8'h5A);
        wait_idle(1100);

        // Zero length: a fresh stream is done from the start.
        write_decoded_length(24'd0);
        send_item(CMD_START, 8'h55);
        send_item(CMD_BYTE, 8'h81);
        wait_idle(1100);

        // Random phases: pick a length, usually start a new stream (else
        // continue the old one), and feed well-formed tokens with some
        // stray starts and raw bytes mixed in.
        while (live_items < 140) begin
            case ($urandom_range(0, 5))
                0:       len_choice = 24'd0;
                1:       len_choice = 24'($urandom_range(1, 12));
                2:       len_choice = 24'($urandom_range(13, 60));
                3:       len_choice = 24'($urandom_range(100, 600));
                default: len_choice = 24'hFFFFFF;
            endcase
            write_decoded_length(len_choice);
            if ($urandom_range(0, 3) != 0) begin
                send_item(CMD_START, 8'($urandom));
                live_items++;
            end
            quota = $urandom_range(10, 40);
            for (int n = 0; n < quota && !sb.done(); n++) begin
                if ($urandom_range(0, 11) == 0) begin
                    if ($urandom_range(0, 1) != 0)
                        send_item(CMD_START, 8'($urandom));
                    else
                        send_item(CMD_BYTE, 8'($urandom));
                end else begin
                    send_token();
                end
                live_items++;
            end
            if (sb.done())
                send_item(CMD_BYTE, 8'($urandom));
            wait_idle(1100);
        end

        wait_idle(300);
        if (sb.fails == 0 && sb.pending_out.size() == 0)
            $display("tb_lzss_ring_decompressor passed");
        else
            $display("tb_lzss_ring_decompressor failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #25_000_000;
        $display("tb_lzss_ring_decompressor failed");
        $finish;
    end

endmodule
